// File: rtl/odo_pkg.sv
// shared constants, types and the arctangent table of the odometry block
package odo_pkg;

   localparam int DEFAULT_CORDIC_STEPS   = 24;
   localparam int DEFAULT_POSE_FRAC_BITS = 16;

   localparam int NUM_W   = 80;
   localparam int DEN_W   = 48;
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int CORD_W  = 34;
   localparam int ANG_W   = 32;
   localparam int TRACK_W = 20;
   localparam int ATAN_IDX_W = 5;

   localparam logic signed [ANG_W-1:0] PI_Q      = 32'sd843314857;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q  = 32'sd1686629713;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q = 32'sd421657428;
   localparam logic signed [CORD_W-1:0] GAIN_Q30 = 34'sd652032874;

   localparam logic [TRACK_W-1:0] TRACK_RESET = 20'd10420;
   localparam logic [MUL_B_W-1:0] USEC_PER_SEC = 32'd1000000;
   localparam logic [DEN_W-1:0]   DS_DIVISOR   = 48'd200;
   localparam logic [DEN_W-1:0]   DTH_SCALE    = 48'd100;
   localparam int DTH_SHIFT  = 44;
   localparam int ANGLE_FRAC = 28;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   function automatic logic [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 32'd210828714;
         5'd1:  v = 32'd124459457;
         5'd2:  v = 32'd65760959;
         5'd3:  v = 32'd33381290;
         5'd4:  v = 32'd16755422;
         5'd5:  v = 32'd8385879;
         5'd6:  v = 32'd4193963;
         5'd7:  v = 32'd2097109;
         5'd8:  v = 32'd1048571;
         5'd9:  v = 32'd524287;
         5'd10: v = 32'd262144;
         5'd11: v = 32'd131072;
         5'd12: v = 32'd65536;
         5'd13: v = 32'd32768;
         5'd14: v = 32'd16384;
         5'd15: v = 32'd8192;
         5'd16: v = 32'd4096;
         5'd17: v = 32'd2048;
         5'd18: v = 32'd1024;
         5'd19: v = 32'd512;
         5'd20: v = 32'd256;
         5'd21: v = 32'd128;
         5'd22: v = 32'd64;
         5'd23: v = 32'd32;
         5'd24: v = 32'd16;
         5'd25: v = 32'd8;
         5'd26: v = 32'd4;
         5'd27: v = 32'd2;
         5'd28: v = 32'd1;
         5'd29: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/odo_divider.sv
// restoring divider, one quotient bit per cycle
module odo_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [odo_pkg::NUM_W-1:0]   num,
   input  logic [odo_pkg::DEN_W-1:0]   den,
   output odo_pkg::unit_status_type    status,
   output logic [odo_pkg::NUM_W-1:0]   quo,
   output logic [odo_pkg::DEN_W-1:0]   rem
);
   import odo_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quo = quo_ff;
   assign rem = rem_ff;

endmodule

// File: rtl/odo_multiplier.sv
// shift and add multiplier, one multiplier bit per cycle
module odo_multiplier (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [odo_pkg::MUL_A_W-1:0]  a,
   input  logic [odo_pkg::MUL_B_W-1:0]  b,
   output odo_pkg::unit_status_type     status,
   output logic [odo_pkg::PROD_W-1:0]   prod
);
   import odo_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);

   logic               busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PROD_W-1:0]  a_ff, a_in, acc_ff, acc_in;
   logic [MUL_B_W-1:0] b_ff, b_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         a_in    = PROD_W'(a);
         b_in    = b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[PROD_W-2:0], 1'b0};
         b_in   = {1'b0, b_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign prod = acc_ff;

endmodule

// File: rtl/odo_cordic.sv
// iterative rotation cordic giving cosine and sine in q30
module odo_cordic #(
   parameter int CORDIC_STEPS = odo_pkg::DEFAULT_CORDIC_STEPS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [odo_pkg::ANG_W-1:0]   angle,
   output odo_pkg::unit_status_type           status,
   output logic signed [odo_pkg::CORD_W-1:0]  cos_out,
   output logic signed [odo_pkg::CORD_W-1:0]  sin_out
);
   import odo_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);

   logic                     busy_ff, busy_in, done_ff, done_in;
   logic [STEP_W-1:0]        cnt_ff, cnt_in;
   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ANG_W-1:0]  z_ff, z_in, at;
   logic                     neg_ff, neg_in;

   always_comb begin
      xs      = x_ff >>> cnt_ff;
      ys      = y_ff >>> cnt_ff;
      at      = $signed(atan_entry(ATAN_IDX_W'(cnt_ff)));
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      if (start) begin
         x_in    = GAIN_Q30;
         y_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         if (angle > HALF_PI_Q) begin
            z_in   = angle - PI_Q;
            neg_in = 1'b1;
         end else if (angle < -HALF_PI_Q) begin
            z_in   = angle + PI_Q;
            neg_in = 1'b1;
         end else begin
            z_in   = angle;
            neg_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

endmodule

// File: rtl/differential_drive_odometry_unit.sv
// differential drive wheel odometry: sequencer, pose state and result register
//
// A request carries cumulative left and right wheel travel in centimetres and
// the microseconds since the previous request. The first request after reset
// only stores a baseline and gives no response. Every later request gives one
// response with the pose, heading and speeds. The track width is written on
// the csr port and holds until written again; the user must write it only
// while the block is idle, which the block itself does not enforce.
// req_ready is high only while the sequencer is idle; one request is worked
// at a time. The work is done by the 80-step restoring divider, used up to
// six times, up to four 32-step multiplier passes and one cordic pass.
// The response sits in an output register; a new request is taken while it
// waits, and the sequencer holds before its last step until rsp_ready frees
// the register. Reset clears the pose, the baseline and the track width to
// its default, and drops any pending response.
module differential_drive_odometry_unit #(
   parameter int CORDIC_STEPS   = odo_pkg::DEFAULT_CORDIC_STEPS,
   parameter int POSE_FRAC_BITS = odo_pkg::DEFAULT_POSE_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_left_travel_cm,
   input  logic signed [31:0]  req_right_travel_cm,
   input  logic [23:0]         req_elapsed_us,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_pos_x,
   output logic signed [31:0]  rsp_pos_y,
   output logic signed [30:0]  rsp_heading,
   output logic signed [31:0]  rsp_linear_speed,
   output logic signed [31:0]  rsp_turn_rate,
   input  logic                csr_wr_en,
   input  logic [19:0]         csr_wr_data
);
   import odo_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DS, S_DTH, S_MID, S_COR, S_MULX, S_MULY, S_HEAD,
      S_LINM, S_LIND, S_TURNM, S_TURND, S_OUT
   } state_type;

   localparam logic [NUM_W:0] DTH_CAP  = (NUM_W + 1)'(1) << 60;
   localparam logic [NUM_W:0] RATE_CAP = (NUM_W + 1)'(1) << 31;
   localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                  input logic [52:0] mag,
                                                  input logic neg);
      logic signed [54:0] s;
      logic signed [54:0] m;
      logic signed [31:0] r;
      m = $signed({2'b00, mag});
      s = neg ? 55'(base) - m : 55'(base) + m;
      if (s > 55'(S32_MAX)) r = S32_MAX;
      else if (s < 55'(S32_MIN)) r = S32_MIN;
      else r = s[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] rate_value(input logic [NUM_W:0] q,
                                                     input logic neg);
      logic signed [31:0] r;
      if (neg) r = (q >= RATE_CAP) ? S32_MIN : -$signed(q[31:0]);
      else r = (q >= RATE_CAP) ? S32_MAX : $signed(q[31:0]);
      return r;
   endfunction

   state_type state_ff, state_in;
   logic launched_ff, launched_in;
   logic [TRACK_W-1:0] track_ff, track_in;
   logic baseline_ff, baseline_in;
   logic [31:0] last_left_ff, last_left_in, last_right_ff, last_right_in;
   logic signed [31:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic signed [31:0] heading_ff, heading_in, mid_ff, mid_in;
   logic [32:0] sum_mag_ff, sum_mag_in, diff_mag_ff, diff_mag_in;
   logic sum_neg_ff, sum_neg_in, diff_neg_ff, diff_neg_in;
   logic [23:0] el_ff, el_in;
   logic [MUL_A_W-1:0] ds_mag_ff, ds_mag_in, dth_mag_ff, dth_mag_in;
   logic signed [31:0] lin_ff, lin_in, turn_ff, turn_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic signed [31:0] out_lin_ff, out_lin_in, out_turn_ff, out_turn_in;
   logic signed [30:0] out_head_ff, out_head_in;

   unit_status_type div_status, mul_status, cor_status;
   logic div_start, mul_start, cor_start;
   logic [NUM_W-1:0] div_num, div_quo;
   logic [DEN_W-1:0] div_den, div_rem;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0] mul_prod, prod_round;
   logic signed [CORD_W-1:0] cos_v, sin_v, cs_v, cs_mag;
   logic [NUM_W:0] rnd;
   logic signed [31:0] dl, dr;
   logic signed [32:0] sum33, diff33;
   logic [TRACK_W-1:0] track_eff;
   logic signed [63:0] hdg64, t_val, t_mag;
   logic [MUL_A_W-1:0] t_sel;
   logic signed [32:0] wr_r, wrapped;
   logic mul_neg;
   logic req_fire;

   odo_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .status(div_status), .quo(div_quo), .rem(div_rem)
   );

   odo_multiplier u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .status(mul_status), .prod(mul_prod)
   );

   odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .angle(mid_ff),
      .status(cor_status), .cos_out(cos_v), .sin_out(sin_v)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      dl = $signed(req_left_travel_cm - last_left_ff);
      dr = $signed(req_right_travel_cm - last_right_ff);
      sum33  = 33'(dl) + 33'(dr);
      diff33 = 33'(dr) - 33'(dl);
      track_eff = (track_ff == '0) ? TRACK_W'(1) : track_ff;

      // angle to wrap: heading plus half or all of the heading change
      hdg64 = 64'(heading_ff);
      t_sel = (state_ff == S_MID) ? (dth_mag_ff >> 1) : dth_mag_ff;
      t_val = diff_neg_ff ? hdg64 - $signed(t_sel) : hdg64 + $signed(t_sel);
      t_mag = t_val[63] ? -t_val : t_val;

      case (state_ff)
         S_DS: begin
            div_num = NUM_W'(sum_mag_ff) << POSE_FRAC_BITS;
            div_den = DS_DIVISOR;
         end
         S_DTH: begin
            div_num = NUM_W'(diff_mag_ff) << DTH_SHIFT;
            div_den = DEN_W'(track_eff) * DTH_SCALE;
         end
         S_MID, S_HEAD: begin
            div_num = NUM_W'(unsigned'(t_mag));
            div_den = DEN_W'(unsigned'(TWO_PI_Q));
         end
         S_LIND: begin
            div_num = mul_prod[NUM_W-1:0];
            div_den = DEN_W'(el_ff);
         end
         S_TURND: begin
            div_num = mul_prod[NUM_W-1:0];
            div_den = DEN_W'(el_ff) << (ANGLE_FRAC - POSE_FRAC_BITS);
         end
         default: begin
            div_num = '0;
            div_den = DEN_W'(1);
         end
      endcase

      cs_v   = (state_ff == S_MULY) ? sin_v : cos_v;
      cs_mag = cs_v[CORD_W-1] ? -cs_v : cs_v;
      case (state_ff)
         S_MULX, S_MULY: begin
            mul_a = ds_mag_ff;
            mul_b = MUL_B_W'(unsigned'(cs_mag));
         end
         S_LINM: begin
            mul_a = ds_mag_ff;
            mul_b = USEC_PER_SEC;
         end
         S_TURNM: begin
            mul_a = dth_mag_ff;
            mul_b = USEC_PER_SEC;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      div_start = !launched_ff && (state_ff inside {S_DS, S_DTH, S_MID, S_HEAD,
                                                    S_LIND, S_TURND});
      mul_start = !launched_ff && (state_ff inside {S_MULX, S_MULY, S_LINM, S_TURNM});
      cor_start = !launched_ff && (state_ff == S_COR);

      // round to nearest, ties away from zero
      rnd = {1'b0, div_quo} +
            (NUM_W + 1)'(({1'b0, div_rem, 1'b0}) >= {2'b00, div_den});

      // remainder signed as the dividend, then folded into minus pi to pi
      wr_r = $signed({2'b00, div_rem[30:0]});
      if (t_val[63]) wr_r = -wr_r;
      if (wr_r > 33'(PI_Q)) wrapped = wr_r - 33'(TWO_PI_Q);
      else if (wr_r < -33'(PI_Q)) wrapped = wr_r + 33'(TWO_PI_Q);
      else wrapped = wr_r;

      prod_round = mul_prod + (PROD_W'(1) << 29);
      mul_neg    = sum_neg_ff ^ cs_v[CORD_W-1];
   end

   always_comb begin
      state_in      = state_ff;
      launched_in   = launched_ff;
      track_in      = track_ff;
      baseline_in   = baseline_ff;
      last_left_in  = last_left_ff;
      last_right_in = last_right_ff;
      pose_x_in     = pose_x_ff;
      pose_y_in     = pose_y_ff;
      heading_in    = heading_ff;
      mid_in        = mid_ff;
      sum_mag_in    = sum_mag_ff;
      sum_neg_in    = sum_neg_ff;
      diff_mag_in   = diff_mag_ff;
      diff_neg_in   = diff_neg_ff;
      el_in         = el_ff;
      ds_mag_in     = ds_mag_ff;
      dth_mag_in    = dth_mag_ff;
      lin_in        = lin_ff;
      turn_in       = turn_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_head_in   = out_head_ff;
      out_lin_in    = out_lin_ff;
      out_turn_in   = out_turn_ff;

      if (csr_wr_en) begin
         track_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (div_start || mul_start || cor_start) begin
         launched_in = 1'b1;
      end
      if (div_status.done || mul_status.done || cor_status.done) begin
         launched_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               last_left_in  = req_left_travel_cm;
               last_right_in = req_right_travel_cm;
               baseline_in   = 1'b1;
               el_in         = req_elapsed_us;
               sum_neg_in    = sum33[32];
               sum_mag_in    = sum33[32] ? unsigned'(-sum33) : unsigned'(sum33);
               diff_neg_in   = diff33[32];
               diff_mag_in   = diff33[32] ? unsigned'(-diff33) : unsigned'(diff33);
               if (baseline_ff) begin
                  state_in = S_DS;
               end
            end
         end
         S_DS: begin
            if (div_status.done) begin
               ds_mag_in = MUL_A_W'(rnd);
               state_in  = S_DTH;
            end
         end
         S_DTH: begin
            if (div_status.done) begin
               dth_mag_in = (rnd > DTH_CAP) ? MUL_A_W'(DTH_CAP) : MUL_A_W'(rnd);
               state_in   = S_MID;
            end
         end
         S_MID: begin
            if (div_status.done) begin
               mid_in   = wrapped[31:0];
               state_in = S_COR;
            end
         end
         S_COR: begin
            if (cor_status.done) begin
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            if (mul_status.done) begin
               pose_x_in = sat_add(pose_x_ff, prod_round[82:30], mul_neg);
               state_in  = S_MULY;
            end
         end
         S_MULY: begin
            if (mul_status.done) begin
               pose_y_in = sat_add(pose_y_ff, prod_round[82:30], mul_neg);
               state_in  = S_HEAD;
            end
         end
         S_HEAD: begin
            if (div_status.done) begin
               heading_in = wrapped[31:0];
               if (el_ff == '0) begin
                  lin_in   = '0;
                  turn_in  = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_LINM;
               end
            end
         end
         S_LINM: begin
            if (mul_status.done) begin
               state_in = S_LIND;
            end
         end
         S_LIND: begin
            if (div_status.done) begin
               lin_in   = rate_value(rnd, sum_neg_ff);
               state_in = S_TURNM;
            end
         end
         S_TURNM: begin
            if (mul_status.done) begin
               state_in = S_TURND;
            end
         end
         S_TURND: begin
            if (div_status.done) begin
               turn_in  = rate_value(rnd, diff_neg_ff);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_x_in     = pose_x_ff;
               out_y_in     = pose_y_ff;
               out_head_in  = heading_ff[30:0];
               out_lin_in   = lin_ff;
               out_turn_in  = turn_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launched_ff  <= 1'b0;
         track_ff     <= TRACK_RESET;
         baseline_ff  <= 1'b0;
         last_left_ff <= '0;
         last_right_ff <= '0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         track_ff     <= track_in;
         baseline_ff  <= baseline_in;
         last_left_ff <= last_left_in;
         last_right_ff <= last_right_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         heading_ff   <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mid_ff      <= mid_in;
      sum_mag_ff  <= sum_mag_in;
      sum_neg_ff  <= sum_neg_in;
      diff_mag_ff <= diff_mag_in;
      diff_neg_ff <= diff_neg_in;
      el_ff       <= el_in;
      ds_mag_ff   <= ds_mag_in;
      dth_mag_ff  <= dth_mag_in;
      lin_ff      <= lin_in;
      turn_ff     <= turn_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_head_ff <= out_head_in;
      out_lin_ff  <= out_lin_in;
      out_turn_ff <= out_turn_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = out_x_ff;
   assign rsp_pos_y        = out_y_ff;
   assign rsp_heading      = out_head_ff;
   assign rsp_linear_speed = out_lin_ff;
   assign rsp_turn_rate    = out_turn_ff;

`ifndef SYNTHESIS
   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!div_status.busy && !mul_status.busy && !cor_status.busy))
      else $error("arithmetic unit busy while idle");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({div_status.busy, mul_status.busy, cor_status.busy}))
      else $error("more than one arithmetic unit busy");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      (heading_ff <= PI_Q) && (heading_ff >= -PI_Q))
      else $error("heading outside minus pi to pi");
`endif

endmodule

// File: sim/odometry_checker.sv
// odometry checker: watches both channels and the csr port, predicts each response and compares
module odometry_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_left_travel_cm,
   input  logic signed [31:0] req_right_travel_cm,
   input  logic [23:0]        req_elapsed_us,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_pos_x,
   input  logic signed [31:0] rsp_pos_y,
   input  logic signed [30:0] rsp_heading,
   input  logic signed [31:0] rsp_linear_speed,
   input  logic signed [31:0] rsp_turn_rate,
   input  logic               csr_wr_en,
   input  logic [19:0]        csr_wr_data,
   output int                 pending_poses,
   output int                 error_count
);
   import odo_pkg::*;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [30:0] heading;
      logic signed [31:0] linear_speed;
      logic signed [31:0] turn_rate;
   } pose_type;

   localparam longint PI_UNITS     = 843314857;
   localparam longint TWO_PI_UNITS = 1686629713;
   localparam longint HALF_PI_UNITS = 421657428;
   localparam longint CORDIC_GAIN  = 652032874;
   localparam int     STEPS        = 24;
   localparam int     FRAC         = 16;

   pose_type     expected_poses[$];
   longint       arctan_units[32];
   logic         have_baseline;
   logic [31:0]  prev_left;
   logic [31:0]  prev_right;
   longint       x_m;
   longint       y_m;
   longint       yaw;
   logic [19:0]  track;

   assign pending_poses = expected_poses.size();

   function automatic bit [63:0] magnitude(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint signed_of(input bit [63:0] m, input bit neg);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint wrap_yaw(input longint t);
      longint r;
      r = t % TWO_PI_UNITS;
      if (r > PI_UNITS) r -= TWO_PI_UNITS;
      if (r < -PI_UNITS) r += TWO_PI_UNITS;
      return r;
   endfunction

   function automatic longint scale_q30(input longint a, input longint c);
      bit [63:0] ua, uc, hi, lo, r;
      ua = magnitude(a);
      uc = magnitude(c);
      hi = ua >> 30;
      lo = ua & ((64'd1 << 30) - 1);
      r = hi * uc + ((lo * uc + (64'd1 << 29)) >> 30);
      return signed_of(r, (a < 0) != (c < 0));
   endfunction

   function automatic longint speed_of(input longint v, input bit [63:0] den);
      bit [63:0] m, q1, r1, q;
      m = magnitude(v);
      q1 = m / den;
      r1 = m % den;
      if (q1 >= (64'd1 << 32)) q = 64'd1 << 31;
      else begin
         q = q1 * 64'd1000000 + (r1 * 64'd1000000 + den / 2) / den;
         if (q > (64'd1 << 31)) q = 64'd1 << 31;
      end
      return clamp32(signed_of(q, v < 0));
   endfunction

   function automatic void integrate_reading(input logic [31:0] left, input logic [31:0] right,
                                             input logic [23:0] el);
      logic [31:0] ul, ur;
      longint dl, dr, sum, diff, ds, dth, mid, cx, sy, xs, ys, z, lin, turn;
      bit [63:0] m, den, q1, r1, q, r2;
      bit neg;
      pose_type p;
      if (!have_baseline) begin
         prev_left = left;
         prev_right = right;
         have_baseline = 1'b1;
         return;
      end
      ul = left - prev_left;
      ur = right - prev_right;
      prev_left = left;
      prev_right = right;
      dl = longint'($signed(ul));
      dr = longint'($signed(ur));
      sum = dl + dr;
      diff = dr - dl;
      m = magnitude(sum) << FRAC;
      ds = signed_of((m + 100) / 200, sum < 0);
      den = 64'd100 * ((track == 0) ? 64'd1 : 64'(track));
      m = magnitude(diff);
      q1 = (m << 22) / den;
      r1 = (m << 22) % den;
      if (q1 >= (64'd1 << 38)) q = 64'd1 << 60;
      else begin
         q = (q1 << 22) + ((r1 << 22) / den);
         r2 = (r1 << 22) % den;
         if (2 * r2 >= den) q++;
         if (q > (64'd1 << 60)) q = 64'd1 << 60;
      end
      dth = signed_of(q, diff < 0);
      mid = wrap_yaw(yaw + dth / 2);
      // fold into the right half plane, then rotate
      neg = 1'b0;
      if (mid > HALF_PI_UNITS) begin
         mid -= PI_UNITS;
         neg = 1'b1;
      end else if (mid < -HALF_PI_UNITS) begin
         mid += PI_UNITS;
         neg = 1'b1;
      end
      cx = CORDIC_GAIN;
      sy = 0;
      z = mid;
      for (int i = 0; i < STEPS; i++) begin
         xs = cx >>> i;
         ys = sy >>> i;
         if (z >= 0) begin
            cx -= ys; sy += xs; z -= arctan_units[i];
         end else begin
            cx += ys; sy -= xs; z += arctan_units[i];
         end
      end
      if (neg) begin
         cx = -cx; sy = -sy;
      end
      x_m = clamp32(x_m + scale_q30(ds, cx));
      y_m = clamp32(y_m + scale_q30(ds, sy));
      yaw = wrap_yaw(yaw + dth);
      lin = 0;
      turn = 0;
      if (el != 0) begin
         lin = speed_of(ds, 64'(el));
         turn = speed_of(dth, 64'(el) << (28 - FRAC));
      end
      p.pos_x = 32'(x_m);
      p.pos_y = 32'(y_m);
      p.heading = 31'(yaw);
      p.linear_speed = 32'(lin);
      p.turn_rate = 32'(turn);
      expected_poses.push_back(p);
   endfunction

   initial begin
      bit [63:0] pw, acc, term;
      int k;
      error_count = 0;
      arctan_units[0] = 210828714;
      for (int i = 1; i < 32; i++) begin
         pw = 64'd1 << (60 - i);
         acc = 0;
         k = 0;
         while (pw != 0) begin
            term = pw / (2 * k + 1);
            if (k & 1) acc -= term;
            else acc += term;
            pw >>= 2 * i;
            k++;
         end
         arctan_units[i] = longint'((acc + (64'd1 << 31)) >> 32);
      end
   end

   always @(posedge clock) begin
      pose_type e;
      if (reset) begin
         expected_poses.delete();
         have_baseline = 1'b0;
         prev_left = 0;
         prev_right = 0;
         x_m = 0;
         y_m = 0;
         yaw = 0;
         track = TRACK_RESET;
      end else begin
         if (csr_wr_en) track = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_poses.size() == 0) begin
               $display("%0t: response with nothing expected", $time);
               error_count++;
            end else begin
               e = expected_poses.pop_front();
               if (rsp_pos_x !== e.pos_x) begin
                  $display("%0t: pos_x expected %0d actual %0d", $time, e.pos_x, rsp_pos_x);
                  error_count++;
               end
               if (rsp_pos_y !== e.pos_y) begin
                  $display("%0t: pos_y expected %0d actual %0d", $time, e.pos_y, rsp_pos_y);
                  error_count++;
               end
               if (rsp_heading !== e.heading) begin
                  $display("%0t: heading expected %0d actual %0d", $time, e.heading,
                           rsp_heading);
                  error_count++;
               end
               if (rsp_linear_speed !== e.linear_speed) begin
                  $display("%0t: linear_speed expected %0d actual %0d", $time,
                           e.linear_speed, rsp_linear_speed);
                  error_count++;
               end
               if (rsp_turn_rate !== e.turn_rate) begin
                  $display("%0t: turn_rate expected %0d actual %0d", $time, e.turn_rate,
                           rsp_turn_rate);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            integrate_reading(req_left_travel_cm, req_right_travel_cm, req_elapsed_us);
      end
   end

endmodule

// File: sim/testbench.sv
// testbench top: clock, reset, request stimulus, track width phases and the verdict
module testbench;
   import odo_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE      = 800;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_left_travel_cm = '0;
   logic signed [31:0] req_right_travel_cm = '0;
   logic [23:0]        req_elapsed_us = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic signed [30:0] rsp_heading;
   logic signed [31:0] rsp_linear_speed;
   logic signed [31:0] rsp_turn_rate;
   logic               csr_wr_en = 1'b0;
   logic [19:0]        csr_wr_data = '0;
   int                 pending_poses;
   int                 error_count;
   int                 quiet_cycles = 0;
   bit                 no_idling = 1'b0;
   logic [31:0]        odo_left = '0;
   logic [31:0]        odo_right = '0;

   always #6 clock = ~clock;

   differential_drive_odometry_unit dut (.*);

   odometry_checker checker_inst (.*);

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= no_idling || ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   task automatic send_reading(input logic [31:0] left, input logic [31:0] right,
                               input logic [23:0] el);
      req_valid <= 1'b1;
      req_left_travel_cm <= left;
      req_right_travel_cm <= right;
      req_elapsed_us <= el;
      odo_left = left;
      odo_right = right;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!no_idling && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   task automatic drain_and_set_track(input logic [19:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_poses != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_reading();
      int pick;
      logic [31:0] l, r;
      logic [23:0] el;
      pick = $urandom_range(99);
      if (pick < 80) begin
         l = odo_left + 32'(int'($urandom_range(4000)) - 2000);
         r = odo_right + 32'(int'($urandom_range(4000)) - 2000);
      end else if (pick < 90) begin
         l = odo_left + $urandom;
         r = odo_right + $urandom;
      end else begin
         l = $urandom;
         r = $urandom;
      end
      pick = $urandom_range(99);
      if (pick < 70) el = 24'($urandom_range(1000, 100000));
      else if (pick < 80) el = '0;
      else el = 24'($urandom);
      send_reading(l, r, el);
   endtask

   task automatic extreme_readings();
      send_reading(32'sh7fffffff, 32'sh80000000, 24'd1);
      send_reading(32'sh80000000, 32'sh7fffffff, 24'hffffff);
      send_reading(32'sh80000000, 32'sh7fffffff, 24'd0);
      send_reading(32'sh00000000, 32'shffffffff, 24'd1);
   endtask

   initial begin
      logic [19:0] tracks[6];
      tracks = '{20'd10420, 20'd655, 20'd655360, 20'd0, 20'd1, 20'd0};
      tracks[5] = 20'($urandom_range(655, 655360));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 6; ph++) begin
         drain_and_set_track(tracks[ph]);
         no_idling = (ph == 2);
         if (ph == 0) begin
            // baseline, standstill, straight runs, spins and wraps
            send_reading(32'sd0, 32'sd0, 24'd100);
            send_reading(32'sd0, 32'sd0, 24'd0);
            send_reading(32'sd1000, 32'sd1000, 24'd1);
            send_reading(32'sd900, 32'sd1100, 24'd20000);
            send_reading(32'sd1, 32'sd2000, 24'd20000);
            send_reading(-32'sd5000, -32'sd5000, 24'd50000);
            send_reading(-32'sd5000, -32'sd4999, 24'd1);
            send_reading(32'sd3000, -32'sd3000, 24'd0);
            extreme_readings();
            send_reading(32'sh7ffffff0, 32'sh7ffffff0, 24'd10);
            send_reading(32'sh80000010, 32'sh80000010, 24'd10);
            for (int i = 0; i < 6; i++)
               send_reading(odo_left - 32'd700, odo_right + 32'd700, 24'd30000);
         end else extreme_readings();
         for (int i = 0; i < 212; i++) random_reading();
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_poses != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule

// File: differential_drive_odometry_unit.f
rtl/odo_pkg.sv
rtl/odo_divider.sv
rtl/odo_multiplier.sv
rtl/odo_cordic.sv
rtl/differential_drive_odometry_unit.sv
sim/odometry_checker.sv
sim/testbench.sv
